FILE: rtl/clst_pkg.sv
`timescale 1ns / 1ps

package clst_pkg;

   // Sizing
   localparam int NAME_MAX     = 63;
   localparam int STRING_STORE = 1024;
   localparam int NAME_LEN_W   = $clog2(NAME_MAX + 1);
   localparam int STR_OFF_W    = $clog2(STRING_STORE + 1);
   localparam int RQ_DEPTH     = 4;
   localparam int RQ_PTR_W     = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W     = $clog2(RQ_DEPTH + 1);

   localparam logic [NAME_LEN_W-1:0] NAME_LIMIT  = NAME_LEN_W'(NAME_MAX);
   localparam logic [STR_OFF_W-1:0]  STORE_LIMIT = STR_OFF_W'(STRING_STORE);

   // Result packing on the output data bus
   localparam int KIND_W     = 4;
   localparam int VALUE_W    = 64;
   localparam int ERR_W      = 3;
   localparam int KIND_LSB   = 0;
   localparam int VALUE_LSB  = KIND_LSB + KIND_W;
   localparam int ERR_LSB    = VALUE_LSB + VALUE_W;
   localparam int RSP_DATA_W = ((ERR_LSB + ERR_W + 7) / 8) * 8;

   // Token kinds
   localparam logic [KIND_W-1:0] K_END   = 4'd0;
   localparam logic [KIND_W-1:0] K_CHAR  = 4'd1;
   localparam logic [KIND_W-1:0] K_NAME  = 4'd2;
   localparam logic [KIND_W-1:0] K_INT   = 4'd3;
   localparam logic [KIND_W-1:0] K_STR   = 4'd4;
   localparam logic [KIND_W-1:0] K_AND   = 4'd5;
   localparam logic [KIND_W-1:0] K_OR    = 4'd6;
   localparam logic [KIND_W-1:0] K_NONE  = 4'd7;
   localparam logic [KIND_W-1:0] K_KW0   = 4'd8;
   localparam logic [KIND_W-1:0] K_NBYTE = 4'd12;
   localparam logic [KIND_W-1:0] K_SBYTE = 4'd13;
   localparam logic [KIND_W-1:0] K_ERR   = 4'd14;

   // Error codes
   localparam logic [ERR_W-1:0] E_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] E_ESCAPE    = 3'd1;
   localparam logic [ERR_W-1:0] E_UNCLOSED  = 3'd2;
   localparam logic [ERR_W-1:0] E_NAME_LONG = 3'd3;
   localparam logic [ERR_W-1:0] E_STORE     = 3'd4;

   // Characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LN     = 8'h6E;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   typedef enum logic [9:0] {
      M_IDLE    = 10'b00_0000_0001,
      M_INT     = 10'b00_0000_0010,
      M_NAME    = 10'b00_0000_0100,
      M_STR     = 10'b00_0000_1000,
      M_ESC     = 10'b00_0001_0000,
      M_SLASH   = 10'b00_0010_0000,
      M_COMMENT = 10'b00_0100_0000,
      M_AMP     = 10'b00_1000_0000,
      M_BAR     = 10'b01_0000_0000,
      M_HALT    = 10'b10_0000_0000
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [ERR_W-1:0]   err;
      logic               last;
   } res_type;

   typedef struct packed {
      logic [1:0] count;
      res_type    res0;
      res_type    res1;
   } push_type;

   // Keyword spellings, padded with zeros
   localparam logic [7:0] KW_TEXT [4][6] = '{
      '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
   };
   localparam logic [2:0] KW_LEN [4] = '{3'd4, 3'd2, 3'd3, 3'd6};

   function automatic logic [7:0] kw_char(input logic [1:0] k,
                                          input logic [NAME_LEN_W-1:0] pos);
      logic [7:0] ch;
      ch = CH_NUL;
      if (pos < NAME_LEN_W'(6)) begin
         ch = KW_TEXT[k][pos[2:0]];
      end
      return ch;
   endfunction

   // Drop candidates whose spelling differs at this position
   function automatic logic [3:0] kw_narrow(input logic [3:0] cand,
                                            input logic [NAME_LEN_W-1:0] pos,
                                            input logic [7:0] b);
      logic [3:0] keep;
      for (int k = 0; k < 4; k++) begin
         keep[k] = cand[k] && (kw_char(2'(k), pos) == b);
      end
      return keep;
   endfunction

endpackage

FILE: rtl/clst_core.sv
`timescale 1ns / 1ps

module clst_core
   import clst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] src_byte,
   output push_type   push
);

   mode_type               mode_ff, mode_in;
   logic [VALUE_W-1:0]     acc_ff, acc_in;
   logic [NAME_LEN_W-1:0]  name_len_ff, name_len_in;
   logic [3:0]             kw_ff, kw_in;
   logic [STR_OFF_W-1:0]   str_off_ff, str_off_in;
   logic [STR_OFF_W-1:0]   str_start_ff, str_start_in;

   logic       is_digit, is_lower, is_upper, is_blank, name_more, store_full;
   logic       f_valid, s_valid, restart;
   res_type    f_res, s_res, slot0, slot1;
   logic [1:0] n_res;
   logic [KIND_W-1:0] name_kind;

   assign is_digit   = (src_byte >= CH_0) && (src_byte <= CH_9);
   assign is_lower   = (src_byte >= CH_LA) && (src_byte <= CH_LZ);
   assign is_upper   = (src_byte >= CH_UA) && (src_byte <= CH_UZ);
   assign is_blank   = (src_byte == CH_SPACE) || (src_byte == CH_TAB) ||
                       (src_byte == CH_LF) || (src_byte == CH_CR);
   assign name_more  = (src_byte == CH_UNDER) || is_lower || is_digit;
   assign store_full = (str_off_ff >= STORE_LIMIT);

   always_comb begin
      name_kind = K_NAME;
      for (int k = 0; k < 4; k++) begin
         if (kw_ff[k] && (name_len_ff == NAME_LEN_W'(KW_LEN[k]))) begin
            name_kind = K_KW0 + KIND_W'(k);
         end
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      name_len_in  = name_len_ff;
      kw_in        = kw_ff;
      str_off_in   = str_off_ff;
      str_start_in = str_start_ff;
      f_valid      = 1'b0;
      f_res        = '0;
      s_valid      = 1'b0;
      s_res        = '0;
      restart      = 1'b0;

      // Finish or extend the token in progress
      unique case (mode_ff)
         M_IDLE: begin
            restart = 1'b1;
         end
         M_INT: begin
            if (is_digit) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + VALUE_W'(src_byte - CH_0);
            end else begin
               f_valid = 1'b1;
               f_res   = '{kind: K_INT, value: acc_ff, err: E_NONE, last: 1'b0};
               restart = 1'b1;
            end
         end
         M_NAME: begin
            if (name_more) begin
               f_valid = 1'b1;
               if (name_len_ff >= NAME_LIMIT) begin
                  f_res   = '{kind: K_ERR, value: '0, err: E_NAME_LONG, last: 1'b0};
                  mode_in = M_HALT;
               end else begin
                  kw_in       = kw_narrow(kw_ff, name_len_ff, src_byte);
                  name_len_in = name_len_ff + 1'b1;
                  f_res = '{kind: K_NBYTE, value: VALUE_W'(src_byte), err: E_NONE,
                            last: 1'b0};
               end
            end else begin
               f_valid = 1'b1;
               f_res   = '{kind: name_kind, value: VALUE_W'(name_len_ff), err: E_NONE,
                           last: 1'b0};
               restart = 1'b1;
            end
         end
         M_STR: begin
            priority if (src_byte == CH_NUL) begin
               f_valid = 1'b1;
               f_res   = '{kind: K_ERR, value: '0, err: E_UNCLOSED, last: 1'b0};
               mode_in = M_HALT;
            end else if (src_byte == CH_BSLASH) begin
               mode_in = M_ESC;
            end else begin
               f_valid = 1'b1;
               if (store_full) begin
                  f_res   = '{kind: K_ERR, value: '0, err: E_STORE, last: 1'b0};
                  mode_in = M_HALT;
               end else if (src_byte == CH_QUOTE) begin
                  // terminator takes a slot in the store
                  str_off_in = str_off_ff + 1'b1;
                  f_res = '{kind: K_STR, value: VALUE_W'(str_start_ff), err: E_NONE,
                            last: 1'b0};
                  mode_in = M_IDLE;
               end else begin
                  str_off_in = str_off_ff + 1'b1;
                  f_res = '{kind: K_SBYTE, value: VALUE_W'(src_byte), err: E_NONE,
                            last: 1'b0};
               end
            end
         end
         M_ESC: begin
            f_valid = 1'b1;
            if (src_byte != CH_LN) begin
               f_res   = '{kind: K_ERR, value: '0, err: E_ESCAPE, last: 1'b0};
               mode_in = M_HALT;
            end else if (store_full) begin
               f_res   = '{kind: K_ERR, value: '0, err: E_STORE, last: 1'b0};
               mode_in = M_HALT;
            end else begin
               str_off_in = str_off_ff + 1'b1;
               f_res = '{kind: K_SBYTE, value: VALUE_W'(CH_LF), err: E_NONE, last: 1'b0};
               mode_in = M_STR;
            end
         end
         M_SLASH: begin
            if (src_byte == CH_SLASH) begin
               mode_in = M_COMMENT;
            end else begin
               f_valid = 1'b1;
               f_res   = '{kind: K_CHAR, value: VALUE_W'(CH_SLASH), err: E_NONE,
                           last: 1'b0};
               restart = 1'b1;
            end
         end
         M_COMMENT: begin
            priority if (src_byte == CH_NUL) begin
               f_valid = 1'b1;
               f_res   = '{kind: K_END, value: '0, err: E_NONE, last: 1'b0};
               mode_in = M_IDLE;
            end else if ((src_byte == CH_LF) || (src_byte == CH_CR)) begin
               mode_in = M_IDLE;
            end else begin
               mode_in = M_COMMENT;
            end
         end
         M_AMP, M_BAR: begin
            f_valid = 1'b1;
            if ((mode_ff == M_AMP) && (src_byte == CH_AMP)) begin
               f_res   = '{kind: K_AND, value: '0, err: E_NONE, last: 1'b0};
               mode_in = M_IDLE;
            end else if ((mode_ff == M_BAR) && (src_byte == CH_BAR)) begin
               f_res   = '{kind: K_OR, value: '0, err: E_NONE, last: 1'b0};
               mode_in = M_IDLE;
            end else begin
               f_res   = '{kind: K_NONE, value: '0, err: E_NONE, last: 1'b0};
               restart = 1'b1;
            end
         end
         M_HALT: begin
            mode_in = M_HALT;
         end
         default: begin
            mode_in = M_HALT;
         end
      endcase

      // Take the byte as the start of a new token
      if (restart) begin
         mode_in = M_IDLE;
         priority if (src_byte == CH_NUL) begin
            s_valid = 1'b1;
            s_res   = '{kind: K_END, value: '0, err: E_NONE, last: 1'b0};
         end else if (is_blank) begin
            mode_in = M_IDLE;
         end else if (is_digit) begin
            acc_in  = VALUE_W'(src_byte - CH_0);
            mode_in = M_INT;
         end else if ((src_byte == CH_UNDER) || is_lower || is_upper) begin
            kw_in       = kw_narrow(4'hF, '0, src_byte);
            name_len_in = NAME_LEN_W'(1);
            s_valid     = 1'b1;
            s_res = '{kind: K_NBYTE, value: VALUE_W'(src_byte), err: E_NONE, last: 1'b0};
            mode_in     = M_NAME;
         end else if (src_byte == CH_QUOTE) begin
            str_start_in = str_off_ff;
            mode_in      = M_STR;
         end else if (src_byte == CH_SLASH) begin
            mode_in = M_SLASH;
         end else if (src_byte == CH_AMP) begin
            mode_in = M_AMP;
         end else if (src_byte == CH_BAR) begin
            mode_in = M_BAR;
         end else begin
            s_valid = 1'b1;
            s_res = '{kind: K_CHAR, value: VALUE_W'(src_byte), err: E_NONE, last: 1'b0};
         end
      end
   end

   // Order the results and mark the final one of the run
   always_comb begin
      slot0 = f_valid ? f_res : s_res;
      slot1 = s_res;
      n_res = 2'(f_valid) + 2'(s_valid);
      if (n_res == 2'd2) begin
         slot1.last = 1'b1;
      end else begin
         slot0.last = 1'b1;
      end
      push.count = fire ? n_res : 2'd0;
      push.res0  = slot0;
      push.res1  = slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_IDLE;
         acc_ff       <= '0;
         name_len_ff  <= '0;
         kw_ff        <= '0;
         str_off_ff   <= '0;
         str_start_ff <= '0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         name_len_ff  <= name_len_in;
         kw_ff        <= kw_in;
         str_off_ff   <= str_off_in;
         str_start_ff <= str_start_in;
      end
   end

endmodule

FILE: rtl/clst_rsp_queue.sv
`timescale 1ns / 1ps

module clst_rsp_queue
   import clst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   output res_type  out_res,
   input  logic     out_ready
);

   res_type               mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   count_ff, count_in;
   logic [RQ_PTR_W-1:0]   wr_next;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // keep space for a full run of two results
   assign room      = (count_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   assign wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RQ_PTR_W'(pop);
   assign count_in  = count_ff + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/c_like_source_tokenizer.sv
`timescale 1ns / 1ps
// An accepted byte is held in the input register and decoded from there; its tokens enter the
//   result queue when the queue has room, and are offered on rsp_ from the queue registers.
// Throughput: one byte per cycle while bytes give at most one token each and the result queue
//   has room; a byte that gives two tokens needs two transfers on the single result port.
// Reset clears the lexer mode, counters and result queue; an error halts output until reset.

module c_like_source_tokenizer
   import clst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] source_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] token_kind, [67:4] token_value,
                                             // [70:68] error_code, [71] zero
   output logic                  rsp_tlast   // last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       room, fire;
   push_type   push;
   res_type    out_res;

   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   clst_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .src_byte (in_byte_ff),
      .push     (push)
   );

   clst_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[KIND_LSB +: KIND_W]   = out_res.kind;
      rsp_tdata[VALUE_LSB +: VALUE_W] = out_res.value;
      rsp_tdata[ERR_LSB +: ERR_W]     = out_res.err;
      rsp_tlast = out_res.last;
   end

   // An error is always the final token of its run
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[KIND_LSB +: KIND_W] == K_ERR)) |-> rsp_tlast)
      else $error("error token not marked last");

   // Error code is set exactly on error tokens
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[KIND_LSB +: KIND_W] == K_ERR) ==
                      (rsp_tdata[ERR_LSB +: ERR_W] != E_NONE)))
      else $error("error code does not match token kind");

   // A byte waiting for queue space stays in the input register
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("pending input byte lost");

endmodule

FILE: tb/token_stream_checker.sv
`timescale 1ns / 1ps

module token_stream_checker
   import clst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] source_byte
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] token_kind, [67:4] token_value,
                                              // [70:68] error_code, [71] zero
   input  logic                  rsp_tlast,   // last_of_run
   output int                    mismatches,
   output int                    tokens_left,
   output int                    tokens_seen
);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [ERR_W-1:0]   code;
      logic               last;
   } token_type;

   // Keyword spellings, right-justified in 48 bits
   localparam logic [47:0] WORD_TEXT [4] = '{"void", "if", "for", "return"};
   localparam int          WORD_LEN  [4] = '{4, 2, 3, 6};

   mode_type    lex_mode;
   logic [63:0] number_acc;
   int          name_len;
   logic [3:0]  word_live;
   int          store_off;
   int          string_start;

   token_type   step_tokens [2];
   int          step_count;
   token_type   token_queue [$];

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CH_0 && b <= CH_9;
   endfunction

   function automatic logic is_lower(input logic [7:0] b);
      return b >= CH_LA && b <= CH_LZ;
   endfunction

   function automatic logic name_begins(input logic [7:0] b);
      return b == CH_UNDER || is_lower(b) || (b >= CH_UA && b <= CH_UZ);
   endfunction

   function automatic logic name_goes_on(input logic [7:0] b);
      return b == CH_UNDER || is_lower(b) || is_digit(b);
   endfunction

   task automatic add_token(input logic [KIND_W-1:0] kind, input logic [63:0] value,
                            input logic [ERR_W-1:0] code);
      if (step_count < 2) begin
         step_tokens[step_count] = '{kind: kind, value: value, code: code, last: 1'b0};
         step_count++;
      end
   endtask

   task automatic halt_with(input logic [ERR_W-1:0] code);
      add_token(K_ERR, 64'd0, code);
      lex_mode = M_HALT;
   endtask

   // Drop keywords whose spelling differs at this position
   task automatic narrow_words(input int pos, input logic [7:0] b);
      for (int k = 0; k < 4; k++) begin
         if (word_live[k] && (pos >= WORD_LEN[k] ||
             WORD_TEXT[k][8*(WORD_LEN[k]-1-pos) +: 8] != b)) begin
            word_live[k] = 1'b0;
         end
      end
   endtask

   task automatic close_name();
      logic [KIND_W-1:0] kind;
      kind = K_NAME;
      for (int k = 0; k < 4; k++) begin
         if (word_live[k] && name_len == WORD_LEN[k]) begin
            kind = K_KW0 + KIND_W'(k);
         end
      end
      add_token(kind, 64'(name_len), E_NONE);
      lex_mode = M_IDLE;
   endtask

   task automatic keep_string_byte(input logic [7:0] b);
      if (store_off >= STRING_STORE) begin
         halt_with(E_STORE);
      end else begin
         store_off++;
         add_token(K_SBYTE, 64'(b), E_NONE);
      end
   endtask

   task automatic start_word(input logic [7:0] b);
      lex_mode = M_IDLE;
      if (b == CH_NUL) begin
         add_token(K_END, 64'd0, E_NONE);
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
         // blanks between tokens give nothing
      end else if (is_digit(b)) begin
         number_acc = 64'(b - CH_0);
         lex_mode   = M_INT;
      end else if (name_begins(b)) begin
         word_live = 4'hF;
         narrow_words(0, b);
         name_len = 1;
         add_token(K_NBYTE, 64'(b), E_NONE);
         lex_mode = M_NAME;
      end else if (b == CH_QUOTE) begin
         string_start = store_off;
         lex_mode     = M_STR;
      end else if (b == CH_SLASH) begin
         lex_mode = M_SLASH;
      end else if (b == CH_AMP) begin
         lex_mode = M_AMP;
      end else if (b == CH_BAR) begin
         lex_mode = M_BAR;
      end else begin
         add_token(K_CHAR, 64'(b), E_NONE);
      end
   endtask

   task automatic lex_byte(input logic [7:0] b);
      logic [7:0] pair;
      step_count = 0;
      case (lex_mode)
         M_IDLE: begin
            start_word(b);
         end
         M_INT: begin
            if (is_digit(b)) begin
               number_acc = number_acc * 64'd10 + 64'(b - CH_0);
            end else begin
               add_token(K_INT, number_acc, E_NONE);
               start_word(b);
            end
         end
         M_NAME: begin
            if (name_goes_on(b)) begin
               if (name_len >= NAME_MAX) begin
                  halt_with(E_NAME_LONG);
               end else begin
                  narrow_words(name_len, b);
                  name_len++;
                  add_token(K_NBYTE, 64'(b), E_NONE);
               end
            end else begin
               close_name();
               start_word(b);
            end
         end
         M_STR: begin
            if (b == CH_NUL) begin
               halt_with(E_UNCLOSED);
            end else if (b == CH_QUOTE) begin
               // the terminator takes a store slot too
               if (store_off >= STRING_STORE) begin
                  halt_with(E_STORE);
               end else begin
                  store_off++;
                  add_token(K_STR, 64'(string_start), E_NONE);
                  lex_mode = M_IDLE;
               end
            end else if (b == CH_BSLASH) begin
               lex_mode = M_ESC;
            end else begin
               keep_string_byte(b);
            end
         end
         M_ESC: begin
            if (b == CH_LN) begin
               lex_mode = M_STR;
               keep_string_byte(CH_LF);
            end else begin
               halt_with(E_ESCAPE);
            end
         end
         M_SLASH: begin
            if (b == CH_SLASH) begin
               lex_mode = M_COMMENT;
            end else begin
               add_token(K_CHAR, 64'(CH_SLASH), E_NONE);
               start_word(b);
            end
         end
         M_COMMENT: begin
            if (b == CH_NUL) begin
               add_token(K_END, 64'd0, E_NONE);
               lex_mode = M_IDLE;
            end else if (b == CH_LF || b == CH_CR) begin
               lex_mode = M_IDLE;
            end
         end
         M_AMP, M_BAR: begin
            pair = (lex_mode == M_AMP) ? CH_AMP : CH_BAR;
            if (b == pair) begin
               add_token((lex_mode == M_AMP) ? K_AND : K_OR, 64'd0, E_NONE);
               lex_mode = M_IDLE;
            end else begin
               add_token(K_NONE, 64'd0, E_NONE);
               start_word(b);
            end
         end
         default: begin
            lex_mode = M_HALT;
         end
      endcase
      if (step_count > 0) begin
         step_tokens[step_count-1].last = 1'b1;
      end
      for (int i = 0; i < step_count; i++) begin
         token_queue.push_back(step_tokens[i]);
      end
   endtask

   task automatic report_bad(input string why, input token_type want, input token_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected kind %0d value %h code %0d last %0b,",
                  why, want.kind, want.value, want.code, want.last);
         $display("   got kind %0d value %h code %0d last %0b",
                  got.kind, got.value, got.code, got.last);
      end
   endtask

   always @(posedge clock) begin
      token_type want;
      token_type got;
      if (reset) begin
         lex_mode     = M_IDLE;
         number_acc   = '0;
         name_len     = 0;
         word_live    = '0;
         store_off    = 0;
         string_start = 0;
         token_queue.delete();
         mismatches   = 0;
         tokens_seen  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{kind:  rsp_tdata[KIND_LSB +: KIND_W],
                    value: rsp_tdata[VALUE_LSB +: VALUE_W],
                    code:  rsp_tdata[ERR_LSB +: ERR_W],
                    last:  rsp_tlast};
            tokens_seen++;
            if (token_queue.size() == 0) begin
               report_bad("token with nothing pending", '0, got);
            end else begin
               want = token_queue.pop_front();
               if (got != want) begin
                  report_bad("token mismatch", want, got);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lex_byte(req_tdata);
         end
      end
      tokens_left = token_queue.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import clst_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int OPENING_LEN      = 25;
   localparam int PHASE_ITEMS      = 600;
   // Shorter phases when the run closes by filling the string store
   localparam int FILL_PHASE_ITEMS = 300;
   localparam int HOLD_CYCLES      = 400;
   localparam int DRAIN_CYCLES     = 16;

   // Short hand-made source: keyword, pairs, lone & and |, names, slash,
   // comment, escaped string, high bytes and end of input
   localparam logic [7:0] OPENING [OPENING_LEN] = '{
      "i", "f", CH_AMP, CH_AMP, "x", CH_BAR, CH_BAR, CH_UNDER, "Z", CH_AMP,
      "1", CH_BAR, CH_SLASH, "a", CH_SLASH, CH_SLASH, CH_LF, CH_QUOTE, CH_BSLASH, CH_LN,
      CH_QUOTE, "~", 8'hFF, 8'h80, CH_NUL
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int               mismatches;
   int               tokens_left;
   int               tokens_seen;
   int               cycle_count   = 0;
   int               send_gap_pct  = 0;
   int               ready_gap_pct = 0;
   logic             hold_rsp      = 1'b0;
   int               hold_at       = OPENING_LEN + 2 * PHASE_ITEMS + PHASE_ITEMS / 2;
   int               sent_count    = 0;
   int               store_used    = 0;
   logic [7:0]       tail          = '0;
   logic [7:0]       chunk [$];
   logic [ERR_W-1:0] closing_error = E_NONE;

   c_like_source_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   token_stream_checker tokens_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .tokens_left (tokens_left),
      .tokens_seen (tokens_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d tokens pending",
                  cycle_count, tokens_left);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= ready_gap_pct);
   end

   // Long receiver stall while the sender keeps offering bytes
   initial begin
      wait (sent_count >= hold_at);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   function automatic logic is_word(input logic [7:0] b);
      return b == CH_UNDER || (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) ||
             (b >= CH_0 && b <= CH_9);
   endfunction

   function automatic logic [7:0] name_head();
      int r;
      r = $urandom_range(52);
      if (r == 0) return CH_UNDER;
      else if (r <= 26) return CH_LA + 8'(r - 1);
      else return CH_UA + 8'(r - 27);
   endfunction

   function automatic logic [7:0] name_tail();
      int r;
      r = $urandom_range(36);
      if (r == 0) return CH_UNDER;
      else if (r <= 26) return CH_LA + 8'(r - 1);
      else return CH_0 + 8'(r - 27);
   endfunction

   task automatic send(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) chunk.push_back(s[i]);
   endtask

   // Build one token's worth of source, mostly well formed
   task automatic make_chunk();
      int         pick;
      int         len;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(3))
            0: add_text("void");
            1: add_text("if");
            2: add_text("for");
            default: add_text("return");
         endcase
      end else if (pick < 15) begin
         // near misses of keywords
         case ($urandom_range(9))
            0: add_text("voi");
            1: add_text("voids");
            2: add_text("i");
            3: add_text("iff");
            4: add_text("fo");
            5: add_text("fore");
            6: add_text("retur");
            7: add_text("returns");
            8: add_text("Void");
            default: add_text("for1");
         endcase
      end else if (pick < 30) begin
         len = ($urandom_range(19) == 0) ? NAME_MAX : $urandom_range(1, 10);
         chunk.push_back(name_head());
         repeat (len - 1) chunk.push_back(name_tail());
      end else if (pick < 45) begin
         case ($urandom_range(9))
            0: add_text("18446744073709551615");
            1: add_text("18446744073709551616");
            2: add_text("9223372036854775808");
            default: repeat ($urandom_range(1, 20)) chunk.push_back(CH_0 + 8'($urandom_range(9)));
         endcase
      end else if (pick < 55) begin
         len = $urandom_range(8);
         if (store_used + len + 1 <= STRING_STORE - 64) begin
            chunk.push_back(CH_QUOTE);
            repeat (len) begin
               if ($urandom_range(9) == 0) begin
                  chunk.push_back(CH_BSLASH);
                  chunk.push_back(CH_LN);
               end else begin
                  do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                  chunk.push_back(b);
               end
            end
            chunk.push_back(CH_QUOTE);
            store_used += len + 1;
         end
      end else if (pick < 62) begin
         chunk.push_back(CH_SLASH);
         chunk.push_back(CH_SLASH);
         repeat ($urandom_range(6)) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_LF || b == CH_CR);
            chunk.push_back(b);
         end
         case ($urandom_range(9))
            0: chunk.push_back(CH_NUL);
            1, 2, 3, 4: chunk.push_back(CH_CR);
            default: chunk.push_back(CH_LF);
         endcase
      end else if (pick < 72) begin
         case ($urandom_range(4))
            0: add_text("&&");
            1: add_text("||");
            2: chunk.push_back(CH_AMP);
            3: chunk.push_back(CH_BAR);
            default: chunk.push_back(CH_SLASH);
         endcase
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
               0: chunk.push_back(CH_SPACE);
               1: chunk.push_back(CH_TAB);
               2: chunk.push_back(CH_LF);
               default: chunk.push_back(CH_CR);
            endcase
         end
      end else if (pick < 94) begin
         // any single nonzero byte but a quote, which would open a string
         do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
         chunk.push_back(b);
      end else begin
         chunk.push_back(CH_NUL);
      end
   endtask

   // Keep words apart and never let two slashes meet by accident
   task automatic emit_chunk();
      if (chunk.size() != 0) begin
         if ((is_word(tail) && is_word(chunk[0])) ||
             (tail == CH_SLASH && chunk[0] == CH_SLASH)) begin
            send(CH_SPACE);
         end
         foreach (chunk[i]) send(chunk[i]);
         tail = chunk[chunk.size()-1];
         chunk.delete();
      end
   endtask

   initial begin
      logic [7:0] b;
      int         count;
      int         closing_pick;
      int         phase_items;
      // Filling the store at the close costs most of a store's worth of bytes
      closing_pick = $urandom_range(3);
      phase_items  = (closing_pick == 3) ? FILL_PHASE_ITEMS : PHASE_ITEMS;
      hold_at      = OPENING_LEN + 2 * phase_items + phase_items / 2;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < OPENING_LEN; i++) send(OPENING[i]);
      store_used = 2;   // the escaped newline and its terminator
      tail       = CH_NUL;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct   = 12;
               ready_gap_pct <= 57;
            end
            1: begin
               send_gap_pct   = 57;
               ready_gap_pct <= 12;
            end
            default: begin
               send_gap_pct   = 0;
               ready_gap_pct <= 0;
            end
         endcase
         while (sent_count < OPENING_LEN + (phase + 1) * phase_items) begin
            make_chunk();
            emit_chunk();
         end
      end

      // One error per run, since only reset leaves the halt
      send(CH_SPACE);
      case (closing_pick)
         0: begin
            closing_error = E_ESCAPE;
            send(CH_QUOTE);
            send(CH_BSLASH);
            do b = 8'($urandom_range(255)); while (b == CH_LN);
            send(b);
         end
         1: begin
            closing_error = E_UNCLOSED;
            send(CH_QUOTE);
            send("u");
            send(CH_NUL);
         end
         2: begin
            closing_error = E_NAME_LONG;
            send(name_head());
            repeat (NAME_MAX) send(name_tail());
         end
         default: begin
            // fill the store exactly, then fail on a byte or on the terminator
            closing_error = E_STORE;
            send(CH_QUOTE);
            count = STRING_STORE - store_used + $urandom_range(1);
            repeat (count) send("q");
            send(CH_QUOTE);
         end
      endcase
      repeat (8) send(8'($urandom_range(255)));
      req_tvalid <= 1'b0;

      repeat (4) @(posedge clock);
      wait (tokens_left == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d source bytes over gapped, stalled and back-pressured traffic,",
               sent_count);
      $display("checked %0d tokens; run closed by error code %0d", tokens_seen, closing_error);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d bad tokens", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
